FILE: src/cc20_pkg.sv
// Shared types, constants and round functions for the ChaCha20 byte stream core.
package cc20_pkg;

  typedef logic [31:0] word_t;
  typedef logic [15:0][31:0] state_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [3:0][63:0] key;
    logic [63:0]      nonce01;
    logic [31:0]      nonce2;
  } cfg_t;

  typedef struct packed {
    logic flush;
    logic key_wr;
  } ctl_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
  } qr_t;

  localparam int IDX_W = 3;
  localparam logic [IDX_W-1:0] REG_KEY01   = 3'd0;
  localparam logic [IDX_W-1:0] REG_KEY23   = 3'd1;
  localparam logic [IDX_W-1:0] REG_KEY45   = 3'd2;
  localparam logic [IDX_W-1:0] REG_KEY67   = 3'd3;
  localparam logic [IDX_W-1:0] REG_NONCE01 = 3'd4;
  localparam logic [IDX_W-1:0] REG_NONCE2  = 3'd5;

  localparam int BLOCK_BYTES = 64;
  localparam int LEFT_W      = $clog2(BLOCK_BYTES);
  localparam int QUEUE_DEPTH = 4;

  localparam word_t SIGMA0 = 32'h61707865;
  localparam word_t SIGMA1 = 32'h3320646e;
  localparam word_t SIGMA2 = 32'h79622d32;
  localparam word_t SIGMA3 = 32'h6b206574;

  function automatic state_t init_state(cfg_t cfg, word_t ctr);
    state_t s;
    s[0]  = SIGMA0;
    s[1]  = SIGMA1;
    s[2]  = SIGMA2;
    s[3]  = SIGMA3;
    s[4]  = cfg.key[0][31:0];
    s[5]  = cfg.key[0][63:32];
    s[6]  = cfg.key[1][31:0];
    s[7]  = cfg.key[1][63:32];
    s[8]  = cfg.key[2][31:0];
    s[9]  = cfg.key[2][63:32];
    s[10] = cfg.key[3][31:0];
    s[11] = cfg.key[3][63:32];
    s[12] = ctr;
    s[13] = cfg.nonce01[31:0];
    s[14] = cfg.nonce01[63:32];
    s[15] = cfg.nonce2;
    return s;
  endfunction

  // One half of a quarter round: rotations 16/12 on the first half, 8/7 on the second.
  function automatic qr_t half_qr(word_t a, word_t b, word_t c, word_t d, logic first);
    qr_t   r;
    word_t x;
    word_t y;
    r.a = a + b;
    x   = d ^ r.a;
    r.d = first ? {x[15:0], x[31:16]} : {x[23:0], x[31:24]};
    r.c = c + r.d;
    y   = b ^ r.c;
    r.b = first ? {y[19:0], y[31:20]} : {y[24:0], y[31:25]};
    return r;
  endfunction

endpackage

FILE: src/cc20_fifo.sv
// Input word queue between the accepting front and the cipher back end.
module cc20_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  cc20_pkg::item_t  in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output cc20_pkg::item_t  out_item
);
  import cc20_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  item_t             mem [QUEUE_DEPTH];
  logic [AW-1:0]     wr_ptr;
  logic [AW-1:0]     rd_ptr;
  logic [AW:0]       count;
  logic              push;
  logic              pop;

  assign in_ready  = count != (AW+1)'(QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign out_item  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: src/cc20_block_gen.sv
// Keystream block generator: iterative double rounds, 4 half quarter rounds per step.
module cc20_block_gen #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  cc20_pkg::ctl_t   ctl,
  input  cc20_pkg::cfg_t   cfg,
  input  cc20_pkg::word_t  ctr_next,
  input  logic             blk_take,
  output logic             blk_valid,
  output cc20_pkg::state_t blk
);
  import cc20_pkg::*;

  localparam int STEPS  = 4 * DOUBLE_ROUNDS;
  localparam int STEP_W = $clog2(STEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);

  typedef enum logic [1:0] {
    G_IDLE,
    G_RUN,
    G_ADD
  } gstate_t;

  gstate_t            state;
  state_t             w;
  state_t             w_next;
  state_t             init;
  logic [STEP_W-1:0]  step;
  logic               first;
  logic               diag;

  assign init  = init_state(cfg, ctr_next);
  assign first = !step[0];
  assign diag  = step[1];

  always_comb begin
    qr_t qr;
    w_next = w;
    if (!diag) begin
      for (int l = 0; l < 4; l++) begin
        qr = half_qr(w[l], w[4 + l], w[8 + l], w[12 + l], first);
        w_next[l]      = qr.a;
        w_next[4 + l]  = qr.b;
        w_next[8 + l]  = qr.c;
        w_next[12 + l] = qr.d;
      end
    end else begin
      for (int l = 0; l < 4; l++) begin
        qr = half_qr(w[l], w[4'(4 + ((l + 1) & 3))], w[4'(8 + ((l + 2) & 3))],
                     w[4'(12 + ((l + 3) & 3))], first);
        w_next[l]                      = qr.a;
        w_next[4'(4 + ((l + 1) & 3))]  = qr.b;
        w_next[4'(8 + ((l + 2) & 3))]  = qr.c;
        w_next[4'(12 + ((l + 3) & 3))] = qr.d;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= G_IDLE;
      blk_valid <= 1'b0;
    end else if (ctl.flush) begin
      state     <= G_IDLE;
      blk_valid <= 1'b0;
    end else begin
      unique case (state)
        G_IDLE: begin
          if (!blk_valid) begin
            w     <= init;
            step  <= '0;
            state <= G_RUN;
          end else if (blk_take) begin
            blk_valid <= 1'b0;
          end
        end
        G_RUN: begin
          w    <= w_next;
          step <= step + 1'b1;
          if (step == LAST_STEP) begin
            state <= G_ADD;
          end
        end
        G_ADD: begin
          for (int i = 0; i < 16; i++) begin
            blk[i] <= w[i] + init[i];
          end
          blk_valid <= 1'b1;
          state     <= G_IDLE;
        end
        default: begin
          state <= G_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: src/cc20_xor_stage.sv
// Back end: current keystream block, block counter and registered output word.
module cc20_xor_stage (
  input  logic              clk,
  input  logic              rst,
  input  cc20_pkg::ctl_t    ctl,
  input  logic              q_valid,
  output logic              q_ready,
  input  cc20_pkg::item_t   q_item,
  input  logic              blk_valid,
  input  cc20_pkg::state_t  blk,
  output logic              blk_take,
  output cc20_pkg::word_t   ctr_next,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        result_byte,
  output logic              result_last
);
  import cc20_pkg::*;

  state_t             cur;
  logic [LEFT_W-1:0]  left;
  word_t              block_counter;
  logic               have_ks;
  logic               out_free;
  logic               fire;
  logic               exhausted;
  logic [7:0]         ks_byte;

  assign exhausted = left == '0;
  assign have_ks   = !exhausted || blk_valid;
  assign out_free  = !out_valid || out_ready;
  assign q_ready   = have_ks && out_free;
  assign fire      = q_valid && q_ready;
  assign blk_take  = fire && exhausted;
  assign ks_byte   = exhausted ? blk[0][7:0] : cur[0][7:0];
  assign ctr_next  = block_counter + 32'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      left          <= '0;
      block_counter <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (ctl.flush) begin
        left <= '0;
        if (ctl.key_wr) begin
          block_counter <= '0;
        end
      end else if (fire) begin
        if (exhausted) begin
          cur           <= blk >> 8;
          left          <= LEFT_W'(BLOCK_BYTES - 1);
          block_counter <= ctr_next;
        end else begin
          cur  <= cur >> 8;
          left <= left - 1'b1;
        end
      end
      if (fire) begin
        result_byte <= q_item.data ^ ks_byte;
        result_last <= q_item.last;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: src/chacha20_stream_xor_core.sv
// ChaCha20 byte stream XOR core: one keystream byte per word, next block built ahead.
// From input accept, a word passes the input queue and the registered output stage while a
// keystream block is ready; the first word after reset or a config write waits for a new block.
// Throughput: 1 word per cycle sustained unless out_ready stalls or no keystream block is ready;
// the round unit builds each 64-byte block while the current block is being used.
// Reset: synchronous; config registers clear to zero, counter 0, no keystream buffered.
module chacha20_stream_xor_core #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        message_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  result_byte,
  output logic        result_last,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import cc20_pkg::*;

  cfg_t    cfg;
  ctl_t    ctl;
  item_t   in_item;
  item_t   q_item;
  logic    q_valid;
  logic    q_ready;
  logic    blk_valid;
  logic    blk_take;
  state_t  blk;
  word_t   ctr_next;

  assign in_item.data = data_byte;
  assign in_item.last = message_end;

  always_comb begin
    ctl = '0;
    if (cfg_we) begin
      case (cfg_index)
        REG_KEY01, REG_KEY23, REG_KEY45, REG_KEY67: begin
          ctl.key_wr = 1'b1;
          ctl.flush  = 1'b1;
        end
        REG_NONCE01, REG_NONCE2: begin
          ctl.flush = 1'b1;
        end
        default: begin
          ctl = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY01:   cfg.key[0]  <= cfg_data;
        REG_KEY23:   cfg.key[1]  <= cfg_data;
        REG_KEY45:   cfg.key[2]  <= cfg_data;
        REG_KEY67:   cfg.key[3]  <= cfg_data;
        REG_NONCE01: cfg.nonce01 <= cfg_data;
        REG_NONCE2:  cfg.nonce2  <= cfg_data[31:0];
        default: begin
        end
      endcase
    end
  end

  cc20_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  cc20_block_gen #(
    .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
  ) u_gen (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .cfg       (cfg),
    .ctr_next  (ctr_next),
    .blk_take  (blk_take),
    .blk_valid (blk_valid),
    .blk       (blk)
  );

  cc20_xor_stage u_xor (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_item      (q_item),
    .blk_valid   (blk_valid),
    .blk         (blk),
    .blk_take    (blk_take),
    .ctr_next    (ctr_next),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_byte (result_byte),
    .result_last (result_last)
  );

  a_take_needs_block: assert property (@(posedge clk) disable iff (rst)
    blk_take |-> blk_valid)
    else $error("keystream block taken while none is ready");

  a_key_resets_counter: assert property (@(posedge clk) disable iff (rst)
    ctl.key_wr |=> ctr_next == 32'd1)
    else $error("key write did not restart the block counter");

  a_flush_drops_block: assert property (@(posedge clk) disable iff (rst)
    ctl.flush |=> !blk_valid)
    else $error("prefetched block survived a config write");

endmodule
